>>> rtl/fpr_pkg.sv
// Shared types and constants for the FIFO page replacement frame table.
`default_nettype none

package fpr_pkg;

	// Default storage sizing
	localparam int MAX_FRAMES_DEF = 16;
	localparam int PAGE_BITS_DEF  = 16;

	// Fixed field widths on the ports
	localparam int PAGE_W  = 16;
	localparam int SLOT_W  = 4;
	localparam int CFG_W   = 5;
	localparam int CNT_W   = 32;

	// frames_in_use after reset
	localparam logic [CFG_W-1:0] FIU_RESET = CFG_W'(16);

	// Output word layout, lowest bit first
	localparam int SLOT_LO  = 0;
	localparam int EVV_LO   = SLOT_LO + SLOT_W;
	localparam int EVP_LO   = EVV_LO + 1;
	localparam int FTOT_LO  = EVP_LO + PAGE_W;
	localparam int HTOT_LO  = FTOT_LO + CNT_W;
	localparam int PACK_W   = HTOT_LO + CNT_W;
	localparam int M_DATA_W = ((PACK_W + 7) / 8) * 8;
	localparam int S_DATA_W = ((PAGE_W + 7) / 8) * 8;

	// Commands from the controller to the datapath
	typedef struct packed {
		logic load_in;
		logic step;
	} fpr_cmd_t;

	// Controller occupancy states
	typedef enum logic [3:0] {
		ST_EMPTY = 4'b0001,
		ST_IN    = 4'b0010,
		ST_OUT   = 4'b0100,
		ST_BOTH  = 4'b1000
	} fpr_state_t;

endpackage

`default_nettype wire

>>> rtl/fifo_page_replacement.sv
// Top level of the FIFO page replacement frame table.
`default_nettype none

// A word accepted into the input register moves on to the result register when that
// register is free or draining, and waits there while m_tready is low.
// Throughput: one page reference per cycle while m_tready is high; the tag compare over the
// window's frames and the table update both finish in the step out of the input register.
// Reset (arst_n low, asynchronous) clears all valid marks, the oldest pointer, both
// counts and sets frames_in_use to 16; frame contents are left undefined, no clearing pass.
module fifo_page_replacement #(
	parameter int MAX_FRAMES = fpr_pkg::MAX_FRAMES_DEF,
	parameter int PAGE_BITS  = fpr_pkg::PAGE_BITS_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	// Configuration write: frames_in_use
	input  wire logic                          cfg_valid,
	output logic                               cfg_ready,
	input  wire logic [fpr_pkg::CFG_W-1:0]     cfg_data,
	// Reference stream
	input  wire logic                          s_tvalid,
	output logic                               s_tready,
	input  wire logic [fpr_pkg::S_DATA_W-1:0]  s_tdata,  // [15:0] page_number
	// Result stream
	output logic                               m_tvalid,
	input  wire logic                          m_tready,
	// [3:0] slot, [4] evicted_valid, [20:5] evicted_page,
	// [52:21] fault_total, [84:53] hit_total, rest zero
	output logic [fpr_pkg::M_DATA_W-1:0]       m_tdata,
	output logic [0:0]                         m_tuser   // [0] hit
);
	import fpr_pkg::*;

	fpr_cmd_t          cmd;
	logic              hit;
	logic [SLOT_W-1:0] slot;
	logic              evicted_valid;
	logic [PAGE_W-1:0] evicted_page;
	logic [CNT_W-1:0]  fault_total;
	logic [CNT_W-1:0]  hit_total;

	// Register writes are taken at once and apply to the next word processed
	assign cfg_ready = 1'b1;

	// Controller: holds occupancy of input and result registers
	fpr_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.cmd      (cmd)
	);

	// Datapath: frame table compare, replacement and counts
	fpr_datapath #(
		.MAX_FRAMES (MAX_FRAMES),
		.PAGE_BITS  (PAGE_BITS)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.cfg_valid     (cfg_valid && cfg_ready),
		.cfg_data      (cfg_data),
		.page_in       (s_tdata[PAGE_W-1:0]),
		.hit           (hit),
		.slot          (slot),
		.evicted_valid (evicted_valid),
		.evicted_page  (evicted_page),
		.fault_total   (fault_total),
		.hit_total     (hit_total)
	);

	// Pack the result word, first field in the lowest bits
	always_comb begin
		m_tdata = '0;
		m_tdata[SLOT_LO +: SLOT_W] = slot;
		m_tdata[EVV_LO]            = evicted_valid;
		m_tdata[EVP_LO +: PAGE_W]  = evicted_page;
		m_tdata[FTOT_LO +: CNT_W]  = fault_total;
		m_tdata[HTOT_LO +: CNT_W]  = hit_total;
	end

	assign m_tuser[0] = hit;

endmodule

`default_nettype wire

>>> rtl/fpr_ctrl.sv
// Controller: tracks the input and output word registers and issues commands.
`default_nettype none

module fpr_ctrl (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            s_tvalid,
	output logic                 s_tready,
	output logic                 m_tvalid,
	input  wire logic            m_tready,
	output fpr_pkg::fpr_cmd_t    cmd
);
	import fpr_pkg::*;

	fpr_state_t state_q;
	fpr_state_t state_d;
	logic       in_full;
	logic       out_full;
	logic       step;
	logic       load;
	logic       in_full_d;
	logic       out_full_d;

	assign in_full  = (state_q == ST_IN) || (state_q == ST_BOTH);
	assign out_full = (state_q == ST_OUT) || (state_q == ST_BOTH);

	// Process the held word when the result register is free or draining
	assign step     = in_full && (!out_full || m_tready);
	assign s_tready = !in_full || step;
	assign load     = s_tvalid && s_tready;
	assign m_tvalid = out_full;

	assign in_full_d  = load || (in_full && !step);
	assign out_full_d = step || (out_full && !m_tready);

	always_comb begin
		unique case ({in_full_d, out_full_d})
			2'b00:   state_d = ST_EMPTY;
			2'b10:   state_d = ST_IN;
			2'b01:   state_d = ST_OUT;
			2'b11:   state_d = ST_BOTH;
			default: state_d = ST_EMPTY;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_EMPTY;
		end else begin
			state_q <= state_d;
		end
	end

	assign cmd.load_in = load;
	assign cmd.step    = step;

`ifndef SYNTHESIS
	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(in_full && !step) |=> in_full)
		else $error("held input word lost");
	a_step_fills_out: assert property (@(posedge clk) disable iff (!arst_n)
		step |=> out_full)
		else $error("processed word did not reach output register");
	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		load |-> (!in_full || step))
		else $error("input register overwritten");
`endif

endmodule

`default_nettype wire

>>> rtl/fpr_datapath.sv
// Datapath: frame table, tag compare, FIFO pointer, counters and result register.
`default_nettype none

module fpr_datapath #(
	parameter int MAX_FRAMES = fpr_pkg::MAX_FRAMES_DEF,
	parameter int PAGE_BITS  = fpr_pkg::PAGE_BITS_DEF
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire fpr_pkg::fpr_cmd_t           cmd,
	input  wire logic                        cfg_valid,
	input  wire logic [fpr_pkg::CFG_W-1:0]   cfg_data,
	input  wire logic [fpr_pkg::PAGE_W-1:0]  page_in,
	output logic                             hit,
	output logic [fpr_pkg::SLOT_W-1:0]       slot,
	output logic                             evicted_valid,
	output logic [fpr_pkg::PAGE_W-1:0]       evicted_page,
	output logic [fpr_pkg::CNT_W-1:0]        fault_total,
	output logic [fpr_pkg::CNT_W-1:0]        hit_total
);
	import fpr_pkg::*;

	localparam int SW  = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
	localparam int NW  = $clog2(MAX_FRAMES + 1);
	localparam int CW  = (NW > CFG_W) ? NW : CFG_W;

	logic [CFG_W-1:0]     fiu_q;
	logic [PAGE_BITS-1:0] page_s1;
	logic [PAGE_BITS-1:0] pages_q [MAX_FRAMES];
	logic [MAX_FRAMES-1:0] valid_q;
	logic [SW-1:0]        oldest_q;
	logic [CNT_W-1:0]     fault_q;
	logic [CNT_W-1:0]     hit_q;

	logic [CW-1:0]        win;
	logic [MAX_FRAMES-1:0] match;
	logic                 hit_any;
	logic [SW-1:0]        hit_slot;
	logic [SW-1:0]        victim;
	logic [SW-1:0]        next_oldest;
	logic                 ev_v;

	logic                 out_hit_q;
	logic [SLOT_W-1:0]    out_slot_q;
	logic                 ev_valid_q;
	logic [PAGE_W-1:0]    ev_page_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fiu_q <= FIU_RESET;
		end else if (cfg_valid) begin
			fiu_q <= cfg_data;
		end
	end

	// Window: zero acts as one, clamp at the table size
	always_comb begin
		if (fiu_q == '0) begin
			win = CW'(1);
		end else if (CW'(fiu_q) > CW'(MAX_FRAMES)) begin
			win = CW'(MAX_FRAMES);
		end else begin
			win = CW'(fiu_q);
		end
	end

	always_comb begin
		for (int i = 0; i < MAX_FRAMES; i++) begin
			match[i] = valid_q[i] && (pages_q[i] == page_s1) && (CW'(i) < win);
		end
	end

	// Lowest matching slot wins
	always_comb begin
		hit_any  = 1'b0;
		hit_slot = '0;
		for (int i = MAX_FRAMES - 1; i >= 0; i--) begin
			if (match[i]) begin
				hit_any  = 1'b1;
				hit_slot = SW'(i);
			end
		end
	end

	assign victim      = (CW'(oldest_q) < win) ? oldest_q : '0;
	assign next_oldest = ((CW'(victim) + CW'(1)) < win) ? SW'(victim + SW'(1)) : '0;
	assign ev_v        = valid_q[victim];

	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			page_s1 <= PAGE_BITS'(page_in);
		end
		if (cmd.step && !hit_any) begin
			pages_q[victim] <= page_s1;
		end
		if (cmd.step) begin
			out_hit_q  <= hit_any;
			out_slot_q <= SLOT_W'(hit_any ? hit_slot : victim);
			ev_valid_q <= !hit_any && ev_v;
			ev_page_q  <= (!hit_any && ev_v) ? PAGE_W'(pages_q[victim]) : '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q  <= '0;
			oldest_q <= '0;
			fault_q  <= '0;
			hit_q    <= '0;
		end else if (cmd.step) begin
			if (hit_any) begin
				if (hit_q != '1) begin
					hit_q <= hit_q + CNT_W'(1);
				end
			end else begin
				valid_q[victim] <= 1'b1;
				oldest_q        <= next_oldest;
				if (fault_q != '1) begin
					fault_q <= fault_q + CNT_W'(1);
				end
			end
		end
	end

	// Counters only move on a step, so the result word reads them directly
	assign hit           = out_hit_q;
	assign slot          = out_slot_q;
	assign evicted_valid = ev_valid_q;
	assign evicted_page  = ev_page_q;
	assign fault_total   = fault_q;
	assign hit_total     = hit_q;

`ifndef SYNTHESIS
	a_fault_fills: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.step && !hit_any) |=> valid_q[$past(victim)])
		else $error("faulted slot not marked valid");
	a_hit_keeps_faults: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.step && hit_any) |=> (fault_q == $past(fault_q)) && (oldest_q == $past(oldest_q)))
		else $error("hit disturbed fault state");
	a_idle_counts: assert property (@(posedge clk) disable iff (!arst_n)
		!cmd.step |=> (fault_q == $past(fault_q)) && (hit_q == $past(hit_q)))
		else $error("counter moved without a step");
`endif

endmodule

`default_nettype wire

>>> tb/sv/testbench.sv
// Self-checking testbench for the FIFO page replacement frame table.
`default_nettype none

module testbench;
	import fpr_pkg::*;

	localparam int CYCLE_LIMIT   = 1000000;
	localparam int PLAN_PHASES   = 12;
	localparam int PHASE_WORDS   = 130;
	localparam int HOLD_CYCLES   = 300;
	localparam int POOL_DEPTH    = 24;
	localparam int TABLE_DEPTH   = MAX_FRAMES_DEF;
	localparam logic [CFG_W-1:0] CFG_NONE_AS_ONE = CFG_W'(0);
	localparam logic [CFG_W-1:0] CFG_ALL_ONES    = '1;

	// Opening references: fill all sixteen frames with the page extremes and bit
	// patterns, hit twice, then wrap the pointer and evict the first two pages.
	localparam logic [PAGE_W-1:0] OPENING_PAGES [20] = '{
		16'h0000, 16'hFFFF, 16'h0000, 16'hFFFF, 16'h8000, 16'h0001, 16'h5555,
		16'hAAAA, 16'h00FF, 16'hFF00, 16'h1234, 16'h4321, 16'h7FFF, 16'hFFFE,
		16'h0F0F, 16'hF0F0, 16'h0002, 16'h0004, 16'h0003, 16'h0000
	};
	// Window sizes per random phase: the limits and values above the table
	// size; every fourth phase draws its size at random instead.
	localparam logic [CFG_W-1:0] WINDOW_PLAN [PLAN_PHASES] = '{
		5'd1, 5'd16, 5'd2, 5'd0, 5'd31, 5'd5, 5'd17, 5'd8, 5'd3, 5'd16, 5'd12, 5'd9
	};

	typedef struct packed {
		logic              hit;
		logic [SLOT_W-1:0] slot;
		logic              evicted_valid;
		logic [PAGE_W-1:0] evicted_page;
		logic [CNT_W-1:0]  fault_total;
		logic [CNT_W-1:0]  hit_total;
	} lookup_result_t;

	logic                clk;
	logic                arst_n    = 1'b0;
	logic                cfg_valid = 1'b0;
	logic                cfg_ready;
	logic [CFG_W-1:0]    cfg_data  = '0;
	logic                s_tvalid  = 1'b0;
	logic                s_tready;
	logic [S_DATA_W-1:0] s_tdata   = '0;  // [15:0] page_number
	logic                m_tvalid;
	logic                m_tready  = 1'b0;
	// [3:0] slot, [4] evicted_valid, [20:5] evicted_page,
	// [52:21] fault_total, [84:53] hit_total, rest zero
	logic [M_DATA_W-1:0] m_tdata;
	logic [0:0]          m_tuser;    // [0] hit

	// Shadow of the frame table, kept in step with every accepted reference
	logic [PAGE_W-1:0] frame_page [TABLE_DEPTH];
	logic              frame_full [TABLE_DEPTH];
	logic [SLOT_W-1:0] oldest;
	logic [CNT_W-1:0]  fault_tally;
	logic [CNT_W-1:0]  hit_tally;
	logic [CFG_W-1:0]  frames_cfg;

	logic [PAGE_W-1:0] pending_pages [$];
	lookup_result_t    expected_results [$];
	logic [PAGE_W-1:0] hot_pages [POOL_DEPTH];

	// Idle control: the sequence below switches gaps per phase and asks once
	// for a long receiver hold-off
	logic src_gaps      = 1'b1;
	logic sink_gaps     = 1'b1;
	logic hold_request  = 1'b0;
	logic hold_done     = 1'b0;
	int   hold_left     = 0;
	int   src_gap       = 0;
	int   sink_gap      = 0;
	int   error_count   = 0;
	int   words_checked = 0;
	int   cycle_count   = 0;

	fifo_page_replacement i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Mostly short gaps, now and then a long one
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		if (r < 98)
			return $urandom_range(4, 10);
		return $urandom_range(20, 50);
	endfunction

	// Look the page up in the shadow table, apply FIFO replacement on a miss,
	// and queue the result word the block must return for it.
	task automatic predict_lookup(input logic [PAGE_W-1:0] page);
		lookup_result_t r;
		int span;
		span = (frames_cfg == 0) ? 1 :
		       (int'(frames_cfg) > TABLE_DEPTH) ? TABLE_DEPTH : int'(frames_cfg);
		r = '0;
		// Only the window takes part; the lowest matching slot wins when stale
		// copies are left over from a wider window
		for (int i = 0; i < span; i++) begin
			if (!r.hit && frame_full[i] && frame_page[i] == page) begin
				r.hit  = 1'b1;
				r.slot = SLOT_W'(i);
			end
		end
		if (r.hit) begin
			if (hit_tally != '1)
				hit_tally++;
		end else begin
			// A pointer left beyond a shrunk window restarts at slot zero
			r.slot = (int'(oldest) < span) ? oldest : '0;
			if (frame_full[r.slot]) begin
				r.evicted_valid = 1'b1;
				r.evicted_page  = frame_page[r.slot];
			end
			frame_page[r.slot] = page;
			frame_full[r.slot] = 1'b1;
			oldest = (int'(r.slot) + 1 < span) ? r.slot + 1'b1 : '0;
			if (fault_tally != '1)
				fault_tally++;
		end
		r.fault_total = fault_tally;
		r.hit_total   = hit_tally;
		expected_results.push_back(r);
	endtask

	task automatic report_mismatch(input string what, input logic [CNT_W-1:0] got,
			input logic [CNT_W-1:0] want);
		$display("mismatch in result word %0d, %s: got %0h, expected %0h",
			words_checked, what, got, want);
		error_count++;
	endtask

	// Wait, sampling away from the active edge, until no word is queued,
	// offered or owed by the block
	task automatic wait_drained();
		do
			@(negedge clk);
		while (pending_pages.size() != 0 || s_tvalid || expected_results.size() != 0);
	endtask

	// Write frames_in_use; only called while the block is idle
	task automatic write_window(input logic [CFG_W-1:0] v);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data  <= v;
		do
			@(posedge clk);
		while (!cfg_ready);
		cfg_valid  <= 1'b0;
		frames_cfg = v;
	endtask

	// Reference driver: predict each accepted word, then offer the next one
	// from the pending queue unless a gap is running. Hold the word while the
	// block stalls.
	always @(posedge clk) begin
		if (arst_n) begin
			if (s_tvalid && s_tready) begin
				predict_lookup(s_tdata[PAGE_W-1:0]);
				src_gap = src_gaps ? pick_gap() : 0;
			end
			if (!s_tvalid || s_tready) begin
				if (src_gap > 0 || pending_pages.size() == 0) begin
					if (src_gap > 0)
						src_gap--;
					s_tvalid <= 1'b0;
				end else begin
					s_tvalid <= 1'b1;
					s_tdata  <= S_DATA_W'(pending_pages.pop_front());
				end
			end
		end
	end

	// Result monitor: check each accepted word against the oldest expectation,
	// then pick the next ready level. The long hold-off is counted here.
	always @(posedge clk) begin
		lookup_result_t want;
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				if (expected_results.size() == 0) begin
					report_mismatch("unexpected word", '0, '0);
				end else begin
					want = expected_results.pop_front();
					if (m_tuser[0] !== want.hit)
						report_mismatch("hit", CNT_W'(m_tuser[0]), CNT_W'(want.hit));
					if (m_tdata[SLOT_LO +: SLOT_W] !== want.slot)
						report_mismatch("slot", CNT_W'(m_tdata[SLOT_LO +: SLOT_W]),
							CNT_W'(want.slot));
					if (m_tdata[EVV_LO] !== want.evicted_valid)
						report_mismatch("evicted_valid", CNT_W'(m_tdata[EVV_LO]),
							CNT_W'(want.evicted_valid));
					if (m_tdata[EVP_LO +: PAGE_W] !== want.evicted_page)
						report_mismatch("evicted_page", CNT_W'(m_tdata[EVP_LO +: PAGE_W]),
							CNT_W'(want.evicted_page));
					if (m_tdata[FTOT_LO +: CNT_W] !== want.fault_total)
						report_mismatch("fault_total", m_tdata[FTOT_LO +: CNT_W],
							want.fault_total);
					if (m_tdata[HTOT_LO +: CNT_W] !== want.hit_total)
						report_mismatch("hit_total", m_tdata[HTOT_LO +: CNT_W],
							want.hit_total);
				end
				words_checked++;
			end
			if (hold_request && !hold_done) begin
				hold_left = HOLD_CYCLES;
				hold_done = 1'b1;
			end
			if (hold_left > 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else if (sink_gap > 0) begin
				sink_gap--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
				sink_gap = sink_gaps ? pick_gap() : 0;
			end
		end
	end

	// Watchdog
	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("testbench: FAIL");
		$finish;
	end

	// Sequence: reset, directed references, then random phases each under its
	// own window size
	initial begin
		logic [CFG_W-1:0] window;
		int reach;
		int r;
		for (int i = 0; i < TABLE_DEPTH; i++) begin
			frame_page[i] = '0;
			frame_full[i] = 1'b0;
		end
		oldest      = '0;
		fault_tally = '0;
		hit_tally   = '0;
		frames_cfg  = FIU_RESET;
		for (int i = 0; i < POOL_DEPTH; i++)
			hot_pages[i] = PAGE_W'($urandom_range(0, 65535));

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		// Reset window of sixteen: fill, hit, wrap and evict
		foreach (OPENING_PAGES[i])
			pending_pages.push_back(OPENING_PAGES[i]);
		wait_drained();

		// A zero window acts as one, with the pointer past it: hit in slot zero,
		// then replace it while slot three still holds the same page
		write_window(CFG_NONE_AS_ONE);
		pending_pages.push_back(16'h0003);
		pending_pages.push_back(16'h0001);
		pending_pages.push_back(16'h0001);
		wait_drained();

		// An oversized window acts as sixteen: two copies match, the lower wins;
		// after slot zero is replaced the upper copy hits
		write_window(CFG_ALL_ONES);
		pending_pages.push_back(16'h0001);
		pending_pages.push_back(16'h0003);
		pending_pages.push_back(16'h0001);
		wait_drained();

		for (int p = 0; p < PLAN_PHASES; p++) begin
			window = (p % 4 == 3) ? CFG_W'($urandom_range(0, 31)) : WINDOW_PLAN[p];
			write_window(window);
			reach = (window == 0) ? 2 : (int'(window) > TABLE_DEPTH) ?
				TABLE_DEPTH + 2 : int'(window) + 2;
			// Refresh part of the pool; the rest keeps pages already in the table
			repeat (6)
				hot_pages[$urandom_range(0, POOL_DEPTH - 1)] =
					PAGE_W'($urandom_range(0, 65535));
			// Phase 2 holds the receiver off while the sender keeps offering;
			// phase 5 runs with no idling at all
			src_gaps  <= (p != 2 && p != 5);
			sink_gaps <= (p != 5);
			if (p == 2)
				hold_request <= 1'b1;
			for (int k = 0; k < PHASE_WORDS; k++) begin
				r = $urandom_range(0, 99);
				if (r < 80)
					pending_pages.push_back(hot_pages[$urandom_range(0, reach)]);
				else if (r < 95)
					pending_pages.push_back(PAGE_W'($urandom_range(0, 65535)));
				else if (r < 97)
					pending_pages.push_back('0);
				else
					pending_pages.push_back('1);
			end
			// Stop sending until every result of the phase is back
			wait_drained();
		end

		// Let any stray word surface before the verdict
		repeat (4) @(posedge clk);
		if (error_count == 0)
			$display("testbench: PASS");
		else
			$display("testbench: FAIL");
		$finish;
	end

endmodule

`default_nettype wire

>>> filelist.f
rtl/fpr_pkg.sv
rtl/fpr_ctrl.sv
rtl/fpr_datapath.sv
rtl/fifo_page_replacement.sv
tb/sv/testbench.sv
